/* hw/rtl/twist_scroll_mode_classifier_core_macros.svh */
// Assertion macros for the twist scroll mode classifier.
// Included by the top level; checks compile out under SYNTHESIS.
`ifndef TWIST_SCROLL_MODE_CLASSIFIER_CORE_MACROS_SVH
`define TWIST_SCROLL_MODE_CLASSIFIER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TWSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TWSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define TWSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TWSC_ASSERT(lbl, prop, msg)
`define TWSC_ASSERT_IMPL(lbl, ante, cons, msg)
`define TWSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/twsc_pkg.sv */
// Shared types and constants of the twist scroll mode classifier.
// No dependencies; used by the divider and the top level.
package twsc_pkg;

  localparam int unsigned DeltaW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned AvgW    = 19;
  localparam int unsigned DivW    = 8;
  localparam int unsigned WinW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 19;

  localparam logic [1:0] OP_REL_X   = 2'd0;
  localparam logic [1:0] OP_REL_Y   = 2'd1;
  localparam logic [1:0] OP_REL_OTH = 2'd2;
  localparam logic [1:0] OP_NON_REL = 2'd3;

  localparam logic [1:0] CODE_X     = 2'd0;
  localparam logic [1:0] CODE_Y     = 2'd1;
  localparam logic [1:0] CODE_WHEEL = 2'd2;
  localparam logic [1:0] CODE_ORIG  = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_SCROLL_DIV = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CURSOR_TH  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCROLL_TH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_EXIT_TH    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SYNC_WIN   = 3'd4;

  localparam logic [DivW-1:0] RST_SCROLL_DIV = 8'd1;
  localparam logic [AvgW-1:0] RST_CURSOR_TH  = 19'd10;
  localparam logic [AvgW-1:0] RST_SCROLL_TH  = 19'd24;
  localparam logic [AvgW-1:0] RST_EXIT_TH    = 19'd4;
  localparam logic [WinW-1:0] RST_SYNC_WIN   = 16'd10;

  typedef struct packed {
    logic [1:0]               opcode;
    logic                     from_right;
    logic signed [DeltaW-1:0] delta;
    logic [TimeW-1:0]         now_ms;
  } twsc_in_t;

  typedef struct packed {
    logic                     pass_on;
    logic [1:0]               out_code;
    logic signed [DeltaW-1:0] out_value;
    logic                     scroll_active;
    logic                     cursor_active;
  } twsc_out_t;

  typedef struct packed {
    logic              start;
    logic [DeltaW-1:0] dividend;
    logic [DivW-1:0]   divisor;
  } twsc_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DeltaW-1:0] quotient;
  } twsc_div_rsp_t;

endpackage

/* hw/rtl/twist_scroll_mode_classifier_core.sv */
// Twist scroll mode classifier: sequencer, averages, mode latches, output stage.
// Y, other and unpaired X items pass S_EVAL and S_MODE (or S_GAP) to S_DONE; a paired X item
// adds S_AVG and S_LATCH, and a wheel value waits in S_DIV for the 16-step divider (twsc_div).
// The input stalls until the result is loaded, so no new item is taken before the last one is
// through, and a stalled output register holds the result back further.
// Asynchronous active-low reset restores registers, averages and latches.
`include "twist_scroll_mode_classifier_core_macros.svh"
module twist_scroll_mode_classifier_core import twsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  twsc_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output twsc_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_GAP, S_AVG, S_LATCH, S_MODE, S_DIV, S_DONE
  } state_e;

  function automatic logic [AvgW-1:0] ema(input logic [AvgW-1:0] cur,
                                          input logic [DeltaW-1:0] mag);
    logic [AvgW+1:0] sum;
    sum = {mag, 3'b000} + {1'b0, cur, 1'b0} + {2'b00, cur};
    return sum[AvgW+1:2];
  endfunction

  function automatic logic [DeltaW-1:0] mag16(input logic signed [DeltaW-1:0] v);
    return v[DeltaW-1] ? DeltaW'(-v) : v;
  endfunction

  state_e state_q;
  twsc_in_t  in_q;
  twsc_out_t out_q;
  logic      out_valid_q;

  logic [DivW-1:0]   scroll_div_q;
  logic [AvgW-1:0]   cursor_th_q;
  logic [AvgW-1:0]   scroll_th_q;
  logic [AvgW-1:0]   exit_th_q;
  logic [WinW-1:0]   sync_win_q;

  logic signed [DeltaW-1:0] rd_q;
  logic signed [DeltaW-1:0] bd_q;
  logic [TimeW-1:0]  rt_q;
  logic [TimeW-1:0]  bt_q;
  logic              scroll_q;
  logic              cursor_q;
  logic [AvgW-1:0]   twist_avg_q;
  logic [AvgW-1:0]   cursor_avg_q;

  logic [TimeW-1:0]  gap_q;
  logic [DeltaW-1:0] mean_q;
  logic              pass_q;
  logic [1:0]        code_q;
  logic signed [DeltaW-1:0] value_q;
  logic              wneg_q;

  logic [TimeW-1:0]  new_rt;
  logic [TimeW-1:0]  new_bt;
  logic [TimeW-1:0]  gap_mag;
  logic [DeltaW:0]   pair_sum;
  logic              same_sign;
  logic              clr;
  logic              cur1;
  logic              scr1;
  logic              cur2;
  logic              scr2;
  logic signed [DeltaW:0] wsum;
  logic signed [DeltaW:0] wsum_adj;
  logic signed [DeltaW-1:0] wmean;
  logic              wheel_ok;
  logic              cursor_hit;
  logic              load_out;

  twsc_div_req_t div_req;
  twsc_div_rsp_t div_rsp;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign new_rt    = in_q.from_right ? in_q.now_ms : rt_q;
  assign new_bt    = in_q.from_right ? bt_q : in_q.now_ms;
  assign gap_mag   = gap_q[TimeW-1] ? TimeW'(-gap_q) : gap_q;
  assign pair_sum  = {1'b0, mag16(rd_q)} + {1'b0, mag16(bd_q)};
  assign same_sign = (rd_q != '0) && (bd_q != '0) && (rd_q[DeltaW-1] == bd_q[DeltaW-1]);

  assign clr  = (cursor_avg_q < exit_th_q) && (twist_avg_q < exit_th_q);
  assign scr1 = scroll_q && !clr;
  assign cur1 = cursor_q && !clr;
  assign cur2 = cur1 || (!scr1 && (cursor_avg_q > cursor_th_q));
  assign scr2 = scr1 || (!cur2 && (twist_avg_q > scroll_th_q));

  assign wsum     = {rd_q[DeltaW-1], rd_q} + {bd_q[DeltaW-1], bd_q};
  assign wsum_adj = wsum + (DeltaW+1)'(wsum[DeltaW]);
  assign wmean    = wsum_adj[DeltaW:1];
  assign wheel_ok = (code_q == CODE_X) && (rd_q != '0) && (bd_q != '0);
  assign cursor_hit = (code_q == CODE_X) && (in_q.from_right ? (rd_q != '0) : (bd_q != '0));

  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign div_req.start    = (state_q == S_MODE) && pass_q && (in_q.opcode != OP_NON_REL)
                            && scroll_q && wheel_ok;
  assign div_req.dividend = mag16(wmean);
  assign div_req.divisor  = (scroll_div_q == '0) ? RST_SCROLL_DIV : scroll_div_q;

  twsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      in_q         <= '0;
      out_q        <= '0;
      gap_q        <= '0;
      mean_q       <= '0;
      pass_q       <= 1'b0;
      code_q       <= CODE_X;
      value_q      <= '0;
      wneg_q       <= 1'b0;
      scroll_div_q <= RST_SCROLL_DIV;
      cursor_th_q  <= RST_CURSOR_TH;
      scroll_th_q  <= RST_SCROLL_TH;
      exit_th_q    <= RST_EXIT_TH;
      sync_win_q   <= RST_SYNC_WIN;
      rd_q         <= '0;
      bd_q         <= '0;
      rt_q         <= '0;
      bt_q         <= '0;
      scroll_q     <= 1'b0;
      cursor_q     <= 1'b0;
      twist_avg_q  <= '0;
      cursor_avg_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_SCROLL_DIV: scroll_div_q <= cfg_data_i[DivW-1:0];
          REG_CURSOR_TH:  cursor_th_q  <= cfg_data_i[AvgW-1:0];
          REG_SCROLL_TH:  scroll_th_q  <= cfg_data_i[AvgW-1:0];
          REG_EXIT_TH:    exit_th_q    <= cfg_data_i[AvgW-1:0];
          REG_SYNC_WIN:   sync_win_q   <= cfg_data_i[WinW-1:0];
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          pass_q <= 1'b1;
          unique case (in_q.opcode) inside
            OP_REL_X: begin
              code_q  <= CODE_X;
              value_q <= in_q.delta;
              if (in_q.from_right) begin
                rd_q <= in_q.delta;
                rt_q <= in_q.now_ms;
              end else begin
                bd_q <= in_q.delta;
                bt_q <= in_q.now_ms;
              end
              gap_q   <= new_rt - new_bt;
              state_q <= S_GAP;
            end
            OP_REL_Y: begin
              code_q       <= in_q.from_right ? CODE_X : CODE_Y;
              value_q      <= DeltaW'(-in_q.delta);
              cursor_avg_q <= ema(cursor_avg_q, mag16(in_q.delta));
              state_q      <= S_MODE;
            end
            OP_REL_OTH, OP_NON_REL: begin
              code_q  <= CODE_ORIG;
              value_q <= in_q.delta;
              state_q <= S_MODE;
            end
            default: ;
          endcase
        end
        S_GAP: begin
          mean_q <= pair_sum[DeltaW:1];
          if (gap_mag <= {{(TimeW-WinW){1'b0}}, sync_win_q}) begin
            state_q <= S_AVG;
          end else begin
            pass_q  <= 1'b0;
            state_q <= S_DONE;
          end
        end
        S_AVG: begin
          cursor_avg_q <= ema(cursor_avg_q, mean_q);
          twist_avg_q  <= same_sign ? ema(twist_avg_q, mean_q) : (twist_avg_q >> 1);
          state_q      <= S_LATCH;
        end
        S_LATCH: begin
          scroll_q <= scr2;
          cursor_q <= cur2;
          state_q  <= S_MODE;
        end
        S_MODE: begin
          state_q <= div_req.start ? S_DIV : S_DONE;
          if (pass_q && (in_q.opcode != OP_NON_REL)) begin
            if (scroll_q) begin
              if (wheel_ok) begin
                wneg_q  <= wmean[DeltaW-1];
                rd_q    <= '0;
                bd_q    <= '0;
              end else begin
                pass_q <= 1'b0;
              end
            end else if (cursor_q) begin
              if (cursor_hit) begin
                rd_q   <= '0;
                bd_q   <= '0;
                pass_q <= 1'b0;
              end
            end else if (code_q == CODE_X) begin
              pass_q <= 1'b0;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            code_q  <= CODE_WHEEL;
            value_q <= wneg_q ? div_rsp.quotient : DeltaW'(-div_rsp.quotient);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_q.pass_on       <= pass_q;
            out_q.out_code      <= code_q;
            out_q.out_value     <= value_q;
            out_q.scroll_active <= scroll_q;
            out_q.cursor_active <= cursor_q;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `TWSC_ASSERT(a_latch_excl, !(scroll_q && cursor_q), "Scroll and cursor latches both set.")
  `TWSC_ASSERT_IMPL(a_div_state, div_rsp.busy, state_q == S_DIV, "Divider busy outside wait.")
  `TWSC_ASSERT_NEXT(a_accept_eval, in_valid_i && !in_stall_o, state_q == S_EVAL, "Item lost.")
  `TWSC_ASSERT_IMPL(a_wheel_pass, out_valid_o && (out_data_o.out_code == CODE_WHEEL),
                    out_data_o.pass_on, "Wheel item stopped.")

endmodule

/* hw/rtl/twsc_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Depends on twsc_pkg for widths and the request and response structs.
module twsc_div import twsc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  twsc_div_req_t req_i,
  output twsc_div_rsp_t rsp_o
);

  localparam logic [3:0] LastIter = 4'(DeltaW - 1);

  logic [DivW-1:0]   rem_q;
  logic [DeltaW-1:0] dvd_q;
  logic [DivW-1:0]   dsr_q;
  logic [3:0]        cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DivW:0]     rem_sh;
  logic              ge;
  logic [DivW:0]     rem_sub;

  assign rem_sh  = {rem_q, dvd_q[DeltaW-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == LastIter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DivW-1:0] : rem_sh[DivW-1:0];
      dvd_q <= {dvd_q[DeltaW-2:0], ge};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule
